// ===== rtl/lidar_ray_circle_caster_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the lidar ray caster
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef LIDAR_RAY_CIRCLE_CASTER_UNIT_ASSERT_SVH
`define LIDAR_RAY_CIRCLE_CASTER_UNIT_ASSERT_SVH

// same-cycle implication
`define LRCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LRCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lrcc_pkg.sv =====
// ---------------------------------------------------------------------------
// lrcc_pkg
// Types, constants and tables shared by the lidar ray caster modules.
// ---------------------------------------------------------------------------
`default_nettype none
package lrcc_pkg;

	localparam int MAX_OBSTACLES_DEF = 64;

	localparam int COORD_W  = 24;
	localparam int RADIUS_W = 23;
	localparam int ANGLE_W  = 16;
	localparam int IDX_W    = 10;
	localparam int NRAYS_W  = 11;
	localparam int DIST_W   = 24;

	// serial divider
	localparam int DIV_W  = 26;
	localparam int DCNT_W = 5;

	// square root: 54-bit radicand, 27-bit root
	localparam int RAD_W  = 54;
	localparam int ROOT_W = 27;
	localparam int SCNT_W = 5;

	// cordic
	localparam int CORDIC_STEPS = 16;
	localparam int CS_W   = 20;
	localparam int Z_W    = 33;
	localparam logic signed [CS_W-1:0] CORDIC_X0 = 20'sd39797;

	// shared multiplier
	localparam int MUL_W  = 28;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic [14:0] DEG_SCALE   = 15'd23040;
	localparam logic [3:0]  QUALITY_HIT = 4'd10;

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_CAST   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	localparam logic REG_NUM_RAYS = 1'b0;
	localparam logic REG_MAX_DIST = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV_MOD,
		ST_DIV_OFF,
		ST_DIV_ANG,
		ST_MD2,
		ST_MD2W,
		ST_OB_RD,
		ST_OB_LD,
		ST_OB_M1,
		ST_OB_M2,
		ST_OB_M3,
		ST_OB_M4,
		ST_OB_M5,
		ST_OB_M6,
		ST_OB_M7,
		ST_OB_M8,
		ST_OB_CHK,
		ST_OB_SQ,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [NRAYS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_W-1:0]   quot;
		logic [NRAYS_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

	typedef struct packed {
		logic               start;
		logic [ANGLE_W-1:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [CS_W-1:0] cs;
		logic signed [CS_W-1:0] sn;
	} cordic_rsp_t;

	// atan(2^-i) in units of 2^32 per turn
	function automatic logic signed [Z_W-1:0] atan_turn(input logic [3:0] i);
		logic signed [Z_W-1:0] v;
		unique case (i)
			4'd0:  v = 33'sd536870912;
			4'd1:  v = 33'sd316933406;
			4'd2:  v = 33'sd167458907;
			4'd3:  v = 33'sd85004756;
			4'd4:  v = 33'sd42667331;
			4'd5:  v = 33'sd21354465;
			4'd6:  v = 33'sd10679838;
			4'd7:  v = 33'sd5340245;
			4'd8:  v = 33'sd2670163;
			4'd9:  v = 33'sd1335087;
			4'd10: v = 33'sd667544;
			4'd11: v = 33'sd333772;
			4'd12: v = 33'sd166886;
			4'd13: v = 33'sd83443;
			4'd14: v = 33'sd41722;
			4'd15: v = 33'sd20861;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lrcc_ram.sv =====
// ---------------------------------------------------------------------------
// lrcc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module lrcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/lrcc_div.sv =====
// ---------------------------------------------------------------------------
// lrcc_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module lrcc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lrcc_pkg::div_req_t req,
	output lrcc_pkg::div_rsp_t     rsp
);
	import lrcc_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]   quo_q;
	logic [NRAYS_W-1:0] rem_q;
	logic [NRAYS_W-1:0] dvs_q;
	logic [NRAYS_W:0]   trial;
	logic               take;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], take};
			rem_q <= take ? NRAYS_W'(trial - {1'b0, dvs_q}) : trial[NRAYS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/lrcc_isqrt.sv =====
// ---------------------------------------------------------------------------
// lrcc_isqrt
// Floor square root, one root bit (two radicand bits) per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module lrcc_isqrt (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lrcc_pkg::sqrt_req_t req,
	output lrcc_pkg::sqrt_rsp_t     rsp
);
	import lrcc_pkg::*;

	localparam int REM_W = ROOT_W + 3;

	logic              busy_q;
	logic              done_q;
	logic [SCNT_W-1:0] cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-3:0]  rem_q;
	logic [REM_W-1:0]  rem_tr;
	logic [REM_W-1:0]  trial;
	logic              take;

	assign rem_tr = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = rem_tr >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SCNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], take};
			// remainder stays below 2*root+1, so the top bit drops out
			rem_q  <= take ? (REM_W-2)'(rem_tr - trial) : rem_tr[REM_W-3:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule
`default_nettype wire

// ===== rtl/lrcc_cordic.sv =====
// ---------------------------------------------------------------------------
// lrcc_cordic
// Rotation-mode cordic, one micro-rotation per cycle, Q16 cos and sin.
// ---------------------------------------------------------------------------
`default_nettype none
module lrcc_cordic (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lrcc_pkg::cordic_req_t req,
	output lrcc_pkg::cordic_rsp_t     rsp
);
	import lrcc_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [3:0]             i_q;
	logic                   flip_q;
	logic signed [CS_W-1:0] x_q;
	logic signed [CS_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic signed [CS_W-1:0] xs;
	logic signed [CS_W-1:0] ys;
	logic signed [ANGLE_W:0] w;
	logic                   flip;

	// fold the left half-plane onto the right one
	always_comb begin
		flip = 1'b0;
		if (req.angle >= 16'd16384 && req.angle < 16'd49152) begin
			w    = $signed({1'b0, req.angle}) - 17'sd32768;
			flip = 1'b1;
		end else if (req.angle >= 16'd49152) begin
			w = $signed({1'b0, req.angle}) - 17'sd65536;
		end else begin
			w = $signed({1'b0, req.angle});
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= CORDIC_X0;
			y_q    <= '0;
			z_q    <= Z_W'(w) <<< 16;
			flip_q <= flip;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_turn(i_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_turn(i_q);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.cs   = flip_q ? -x_q : x_q;
	assign rsp.sn   = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

// ===== rtl/lidar_ray_circle_caster_unit.sv =====
// ---------------------------------------------------------------------------
// lidar_ray_circle_caster_unit
// Simulated lidar: circle obstacle table and single-ray caster.
// ---------------------------------------------------------------------------
// Clear (mode 0), append (mode 1) and unused mode 3 items give no result. A
// cast item (mode 2) first runs three serial divides for the ray angles,
// with the cordic running under the last one, then handles each stored
// obstacle: it stops early when the centre lies out of range or the ray
// misses it, and otherwise runs the serial square root. The cast is paced
// by the one shared 28x28 multiplier that does every product of the
// quadratic in turn, and by the serial divider and square root. s_tready is
// low while a ray is cast. The finished result sits in an output register,
// so the next item is taken while it waits. Appends beyond MAX_OBSTACLES
// entries are dropped.
// ---------------------------------------------------------------------------
`default_nettype none
`include "lidar_ray_circle_caster_unit_assert.svh"
module lidar_ray_circle_caster_unit #(
	parameter int MAX_OBSTACLES = lrcc_pkg::MAX_OBSTACLES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// obstacle_x_in[23:0], obstacle_y_in[47:24], obstacle_radius_in[70:48],
	// robot_x[94:71], robot_y[118:95], robot_heading[134:119],
	// ray_index[144:135], zero fill
	input  wire logic [151:0] s_tdata,
	// mode[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// ray_index_out[9:0], angle_deg_q6[24:10], distance[40:25],
	// quality[44:41], valid_res[45], zero fill
	output logic [47:0]       m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [23:0]  cfg_data
);
	import lrcc_pkg::*;

	localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
	localparam int AW    = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int ENT_W = 2 * COORD_W + RADIUS_W;

	state_t state_q, state_d;

	logic [NRAYS_W-1:0] num_rays_q;
	logic [DIST_W-1:0]  max_dist_q;
	logic [CNT_W-1:0]   obs_count_q;
	logic [CNT_W-1:0]   k_q;

	logic signed [COORD_W-1:0] rx_q, ry_q;
	logic [ANGLE_W-1:0] heading_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   b_q;
	logic [14:0]        ang_q;
	logic [2*DIST_W-1:0] md2_q;
	logic signed [COORD_W:0] fx_q, fy_q;
	logic [RADIUS_W-1:0] r_q;
	logic signed [PROD_W-1:0] p_q, acc_q, disc_q;
	logic [49:0]        d2_q;
	logic signed [MUL_W-1:0] h_q;
	logic [DIST_W-1:0]  closest_q;

	logic               m_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [14:0]        out_ang_q;
	logic [15:0]        out_dist_q;
	logic [3:0]         out_qual_q;
	logic               out_hit_q;

	logic s_fire, is_cast, is_append, is_clear, out_free, last_obs, obs_end, out_load;
	logic [NRAYS_W-1:0] nr;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] sum_c;
	logic signed [ROOT_W+2:0] t_c;
	logic t_better;

	logic             ram_we;
	logic [ENT_W-1:0] ram_wdata, ram_rdata;
	logic signed [COORD_W-1:0] ent_x, ent_y;
	logic [RADIUS_W-1:0] ent_r;

	div_req_t    div_req;
	div_rsp_t    div_rsp;
	sqrt_req_t   sq_req;
	sqrt_rsp_t   sq_rsp;
	cordic_req_t cor_req;
	cordic_rsp_t cor_rsp;

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign s_fire    = s_tvalid && s_tready;
	assign is_cast   = s_fire && s_tuser == MODE_CAST;
	assign is_append = s_fire && s_tuser == MODE_APPEND;
	assign is_clear  = s_fire && s_tuser == MODE_CLEAR;
	assign out_free  = !m_valid_q || m_tready;
	assign nr        = (num_rays_q == '0) ? NRAYS_W'(1) : num_rays_q;
	assign last_obs  = (k_q + 1'b1) == obs_count_q;
	assign sum_c     = acc_q + p_q;

	assign t_c = -(ROOT_W+3)'(h_q) - $signed({3'b000, sq_rsp.root});
	assign t_better = t_c > 0 && t_c < $signed({6'b0, closest_q});

	assign ram_wdata = {s_tdata[70:48], s_tdata[47:24], s_tdata[23:0]};
	assign ent_x = ram_rdata[COORD_W-1:0];
	assign ent_y = ram_rdata[2*COORD_W-1:COORD_W];
	assign ent_r = ram_rdata[ENT_W-1:2*COORD_W];

	lrcc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_OBSTACLES)
	) u_obs_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(obs_count_q[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(k_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	lrcc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	lrcc_cordic u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (cor_req),
		.rsp   (cor_rsp)
	);

	lrcc_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sq_req),
		.rsp   (sq_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (is_cast) state_d = ST_DIV_MOD;
			ST_DIV_MOD: if (div_rsp.done) state_d = ST_DIV_OFF;
			ST_DIV_OFF: if (div_rsp.done) state_d = ST_DIV_ANG;
			ST_DIV_ANG: if (div_rsp.done) state_d = ST_MD2;
			ST_MD2:     state_d = ST_MD2W;
			ST_MD2W:    state_d = (obs_count_q == '0) ? ST_OUT : ST_OB_RD;
			ST_OB_RD:   state_d = ST_OB_LD;
			ST_OB_LD:   state_d = ST_OB_M1;
			ST_OB_M1:   state_d = ST_OB_M2;
			ST_OB_M2:   state_d = ST_OB_M3;
			ST_OB_M3:   state_d = ST_OB_M4;
			ST_OB_M4: begin
				if (d2_q > {2'b00, md2_q}) begin
					state_d = last_obs ? ST_OUT : ST_OB_RD;
				end else begin
					state_d = ST_OB_M5;
				end
			end
			ST_OB_M5:   state_d = ST_OB_M6;
			ST_OB_M6:   state_d = ST_OB_M7;
			ST_OB_M7:   state_d = ST_OB_M8;
			ST_OB_M8:   state_d = ST_OB_CHK;
			ST_OB_CHK: begin
				if (disc_q < 0) begin
					state_d = last_obs ? ST_OUT : ST_OB_RD;
				end else begin
					state_d = ST_OB_SQ;
				end
			end
			ST_OB_SQ:   if (sq_rsp.done) state_d = last_obs ? ST_OUT : ST_OB_RD;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// unit requests, multiplier operands, strobes
	always_comb begin
		div_req  = '0;
		cor_req  = '0;
		sq_req   = '0;
		mul_a    = '0;
		mul_b    = '0;
		ram_we   = 1'b0;
		obs_end  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ram_we = is_append && obs_count_q < CNT_W'(MAX_OBSTACLES);
				// ray_index mod num_rays keeps the angles wrapped to one turn
				div_req.start    = is_cast;
				div_req.dividend = DIV_W'(s_tdata[144:135]);
				div_req.divisor  = nr;
			end
			ST_DIV_MOD: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {div_rsp.rem[IDX_W-1:0], 16'h0000};
				div_req.divisor  = nr;
			end
			ST_DIV_OFF: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = DIV_W'(b_q) * DIV_W'(DEG_SCALE);
				div_req.divisor  = nr;
				cor_req.start    = div_rsp.done;
				cor_req.angle    = heading_q - div_rsp.quot[ANGLE_W-1:0];
			end
			ST_MD2: begin
				mul_a = MUL_W'(max_dist_q);
				mul_b = MUL_W'(max_dist_q);
			end
			ST_OB_M1: begin
				mul_a = MUL_W'(fx_q);
				mul_b = MUL_W'(fx_q);
			end
			ST_OB_M2: begin
				mul_a = MUL_W'(fy_q);
				mul_b = MUL_W'(fy_q);
			end
			ST_OB_M3: begin
				mul_a = MUL_W'(fx_q);
				mul_b = MUL_W'(cor_rsp.cs);
			end
			ST_OB_M4: begin
				mul_a   = MUL_W'(fy_q);
				mul_b   = MUL_W'(cor_rsp.sn);
				obs_end = d2_q > {2'b00, md2_q};
			end
			ST_OB_M6: begin
				mul_a = h_q;
				mul_b = h_q;
			end
			ST_OB_M7: begin
				mul_a = MUL_W'(r_q);
				mul_b = MUL_W'(r_q);
			end
			ST_OB_CHK: begin
				obs_end         = disc_q < 0;
				sq_req.start    = !(disc_q < 0);
				sq_req.radicand = disc_q[RAD_W-1:0];
			end
			ST_OB_SQ: obs_end = sq_rsp.done;
			ST_OUT:   out_load = out_free;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_rays_q  <= NRAYS_W'(360);
			max_dist_q  <= DIST_W'(2560);
			obs_count_q <= '0;
			k_q         <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_NUM_RAYS: num_rays_q <= cfg_data[NRAYS_W-1:0];
					REG_MAX_DIST: max_dist_q <= cfg_data;
					default: ;
				endcase
			end
			if (is_clear) begin
				obs_count_q <= '0;
			end else if (ram_we) begin
				obs_count_q <= obs_count_q + 1'b1;
			end
			if (state_q == ST_MD2W) begin
				k_q <= '0;
			end else if (obs_end) begin
				k_q <= k_q + 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (is_cast) begin
			rx_q      <= s_tdata[94:71];
			ry_q      <= s_tdata[118:95];
			heading_q <= s_tdata[134:119];
			idx_q     <= s_tdata[144:135];
		end
		if (state_q == ST_DIV_MOD && div_rsp.done) b_q <= div_rsp.rem[IDX_W-1:0];
		if (state_q == ST_DIV_ANG && div_rsp.done) ang_q <= div_rsp.quot[14:0];
		if (state_q == ST_MD2W) begin
			md2_q     <= p_q[2*DIST_W-1:0];
			closest_q <= max_dist_q;
		end
		if (state_q == ST_OB_LD) begin
			fx_q <= (COORD_W+1)'(rx_q) - (COORD_W+1)'(ent_x);
			fy_q <= (COORD_W+1)'(ry_q) - (COORD_W+1)'(ent_y);
			r_q  <= ent_r;
		end
		if (state_q == ST_OB_M2 || state_q == ST_OB_M4 || state_q == ST_OB_M7) begin
			acc_q <= p_q;
		end
		if (state_q == ST_OB_M3) d2_q <= sum_c[49:0];
		// floor of the Q16 scale-down: plain bit drop
		if (state_q == ST_OB_M5) h_q <= sum_c[16+MUL_W-1:16];
		if (state_q == ST_OB_M8) disc_q <= sum_c - $signed({6'b0, d2_q});
		if (state_q == ST_OB_SQ && sq_rsp.done && t_better) begin
			closest_q <= t_c[DIST_W-1:0];
		end
		if (out_load) begin
			out_idx_q <= idx_q;
			out_ang_q <= ang_q;
			if (closest_q < max_dist_q) begin
				out_dist_q <= closest_q[DIST_W-1:8];
				out_qual_q <= QUALITY_HIT;
				out_hit_q  <= 1'b1;
			end else begin
				out_dist_q <= '0;
				out_qual_q <= '0;
				out_hit_q  <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_hit_q, out_qual_q, out_dist_q, out_ang_q, out_idx_q};

	`LRCC_ASSERT_IMP(a_count_bound, 1'b1, obs_count_q <= CNT_W'(MAX_OBSTACLES), "obstacle count past table size")
	`LRCC_ASSERT_IMP(a_result_consistent, m_valid_q, out_hit_q ? (out_qual_q == QUALITY_HIT) : (out_qual_q == 4'd0 && out_dist_q == 16'd0), "result fields disagree")
	`LRCC_ASSERT_NXT(a_cast_starts_divide, is_cast, state_q == ST_DIV_MOD && !s_tready, "cast item did not start the divider")

endmodule
`default_nettype wire
